// File: rtl/gir_pkg.sv
// shared types, constants and helpers for the graded-index ray refractor
// no dependencies; imported by every rtl module of the block
package gir_pkg;

	// index polynomial in q1.30: n(t) = c - (bk*t >> 18) - (ak*t*t >> 34)
	localparam logic [31:0] IDX_C30 = 32'd1431297851;
	localparam logic [25:0] IDX_BK  = 26'd39945257;
	localparam logic [28:0] IDX_AK  = 29'd367043370;

	// 0.001 in q1.30
	localparam logic signed [32:0] EPS30 = 33'sd1073742;
	localparam logic [15:0] UNIT14 = 16'd16384;

	localparam logic [31:0] TEMP_MAX = 32'd24320;
	localparam logic [31:0] BAND_MAX = 32'd131072;

	// register indexes
	localparam logic [1:0] REG_TOP  = 2'd0;
	localparam logic [1:0] REG_BOT  = 2'd1;
	localparam logic [1:0] REG_BAND = 2'd2;

	// height class of an item
	localparam logic [1:0] CLS_TOP  = 2'd0;
	localparam logic [1:0] CLS_BOT  = 2'd1;
	localparam logic [1:0] CLS_BAND = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// one classified item waiting for the back end
	typedef struct packed {
		logic [1:0]       cls;
		logic [18:0]      w;
		logic [2:0][15:0] c;
		logic [14:0]      prior;
		logic [31:0]      l2;
	} item_t;

	// register view handed to the front and back ends
	typedef struct packed {
		logic signed [31:0] ntop;
		logic signed [31:0] nbot;
		logic [17:0]        band;
	} cfg_t;

	function automatic logic signed [15:0] clamp_mag(input logic [63:0] m, input logic neg);
		logic [15:0] v;
		v = (m > 64'(UNIT14)) ? UNIT14 : m[15:0];
		return neg ? -$signed(v) : $signed(v);
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] x);
		return x[15] ? 16'(-x) : x;
	endfunction

endpackage

// File: rtl/gir_cfg.sv
// configuration registers with apb access and the precomputed layer indices
// depends on gir_pkg
module gir_cfg import gir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg,
	output logic        recalc
);

	localparam logic [1:0] RECALC_CYC = 2'd3;

	logic [14:0] top_q, bot_q;
	logic [17:0] band_q;
	logic [1:0]  recalc_q;
	logic        wr;

	logic [29:0] t2top_s1, t2bot_s1;
	logic [22:0] tbtop_s1, tbbot_s1, tbtop_s2, tbbot_s2;
	logic [24:0] tatop_s2, tabot_s2;
	logic [31:0] ntop_s3, nbot_s3;
	logic [40:0] ptop, pbot;
	logic [58:0] qtop, qbot;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bot_q    <= '0;
			band_q   <= '0;
			recalc_q <= RECALC_CYC;
		end else begin
			if (wr)
				recalc_q <= RECALC_CYC;
			else if (recalc_q != 2'd0)
				recalc_q <= recalc_q - 2'd1;
			if (wr) begin
				case (paddr[3:2])
					REG_TOP: begin
						if (pwdata <= TEMP_MAX) top_q <= pwdata[14:0];
					end
					REG_BOT: begin
						if (pwdata <= TEMP_MAX) bot_q <= pwdata[14:0];
					end
					REG_BAND: begin
						if (pwdata <= BAND_MAX) band_q <= pwdata[17:0];
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TOP:  prdata = {17'd0, top_q};
			REG_BOT:  prdata = {17'd0, bot_q};
			REG_BAND: prdata = {14'd0, band_q};
			default:  prdata = '0;
		endcase
	end

	assign ptop = IDX_BK * top_q;
	assign pbot = IDX_BK * bot_q;
	assign qtop = IDX_AK * t2top_s1;
	assign qbot = IDX_AK * t2bot_s1;

	// index polynomial, three stages, refreshed continuously
	always_ff @(posedge clk) begin
		t2top_s1 <= top_q * top_q;
		t2bot_s1 <= bot_q * bot_q;
		tbtop_s1 <= ptop[40:18];
		tbbot_s1 <= pbot[40:18];
		tbtop_s2 <= tbtop_s1;
		tbbot_s2 <= tbbot_s1;
		tatop_s2 <= qtop[58:34];
		tabot_s2 <= qbot[58:34];
		ntop_s3  <= IDX_C30 - {9'd0, tbtop_s2} - {7'd0, tatop_s2};
		nbot_s3  <= IDX_C30 - {9'd0, tbbot_s2} - {7'd0, tabot_s2};
	end

	assign cfg.ntop = $signed(ntop_s3);
	assign cfg.nbot = $signed(nbot_s3);
	assign cfg.band = band_q;
	assign recalc = (recalc_q != 2'd0);

endmodule

// File: rtl/gir_front.sv
// front end: takes items, classifies the height, squares the direction
// and holds classified items in a short queue; depends on gir_pkg
module gir_front import gir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               recalc,
	input  logic [17:0]        band,
	input  logic signed [23:0] height,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [14:0]        prior_index,
	input  logic               pop,
	output logic               busy,
	output logic               empty,
	output item_t              head
);

	logic signed [25:0] h2, lpos, lneg, wsum;
	logic [1:0]         cls;
	logic               acc;

	logic               vld_s1;
	logic [1:0]         cls_s1;
	logic [18:0]        w_s1;
	logic [2:0][15:0]   c_s1;
	logic [14:0]        prior_s1;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic signed [31:0] px, py, pz;

	item_t              q_mem [QDEPTH];
	logic [QAW-1:0]     wp_q, rp_q;
	logic [QAW:0]       cnt_q;

	assign h2   = {height[23], height, 1'b0};
	assign lpos = {8'd0, band};
	assign lneg = -lpos;
	assign wsum = h2 + lpos;

	always_comb begin
		if (h2 > lpos)
			cls = CLS_TOP;
		else if (h2 < lneg)
			cls = CLS_BOT;
		else if (band == 18'd0)
			cls = CLS_BOT;
		else
			cls = CLS_BAND;
	end

	// room is reserved for the item in s1 before a new one is taken
	assign busy = recalc || ((cnt_q + {{QAW{1'b0}}, vld_s1}) >= (QAW+1)'(QDEPTH));
	assign acc  = start && !busy;
	assign empty = (cnt_q == '0);

	assign px = dir_x * dir_x;
	assign py = dir_y * dir_y;
	assign pz = dir_z * dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cls_s1   <= cls;
			w_s1     <= wsum[18:0];
			c_s1     <= {dir_z, dir_y, dir_x};
			prior_s1 <= prior_index;
			sqx_s1   <= px[30:0];
			sqy_s1   <= py[30:0];
			sqz_s1   <= pz[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			q_mem[wp_q].cls   <= cls_s1;
			q_mem[wp_q].w     <= w_s1;
			q_mem[wp_q].c     <= c_s1;
			q_mem[wp_q].prior <= prior_s1;
			q_mem[wp_q].l2    <= {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (vld_s1) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{QAW{1'b0}}, vld_s1} - {{QAW{1'b0}}, pop};
		end
	end

	assign head = q_mem[rp_q];

endmodule

// File: rtl/gir_back.sv
// back end: sequencer over a shared serial multiplier, long divider and
// square root unit that blends, normalizes and refracts; depends on gir_pkg
module gir_back import gir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  logic               empty,
	input  cfg_t               cfg,
	output logic               pop,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [14:0]        next_index,
	output logic               reflected,
	output logic               done
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_BLMUL  = 4'd1;
	localparam logic [3:0] S_BLDIV  = 4'd2;
	localparam logic [3:0] S_IDX    = 4'd3;
	localparam logic [3:0] S_SQRT   = 4'd4;
	localparam logic [3:0] S_NSTART = 4'd5;
	localparam logic [3:0] S_NDIV   = 4'd6;
	localparam logic [3:0] S_CHK    = 4'd7;
	localparam logic [3:0] S_KDIV   = 4'd8;
	localparam logic [3:0] S_K2     = 4'd9;
	localparam logic [3:0] S_YSQ    = 4'd10;
	localparam logic [3:0] S_PROD   = 4'd11;
	localparam logic [3:0] S_YSQRT  = 4'd12;
	localparam logic [3:0] S_XM     = 4'd13;
	localparam logic [3:0] S_ZM     = 4'd14;

	localparam logic [5:0]  DIV_STEPS = 6'd48;
	localparam logic [63:0] SQ_TOP    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] PROD_LIM  = 64'h1000_0000_0000_0000;
	localparam logic [30:0] ONE30     = 31'h4000_0000;

	logic [3:0]         state_q;
	item_t              e_q;
	logic signed [31:0] n30_q;
	logic               dneg_q, chg_q;
	logic [15:0]        cur14_q;
	logic [31:0]        s_q;
	logic [1:0]         comp_q;
	logic signed [15:0] n_q [3];
	logic [44:0]        k30_q;
	logic [33:0]        k2_q;
	logic signed [15:0] rx_q, ry_q;

	logic [63:0] mul_a_q, mul_acc_q;
	logic [44:0] mul_b_q;
	logic [47:0] div_q_q;
	logic [31:0] div_r_q, div_d_q;
	logic [5:0]  div_n_q;
	logic [63:0] sq_v_q, sq_r_q, sq_b_q;

	logic signed [15:0] res_x_q, res_y_q, res_z_q;
	logic [14:0]        res_n_q;
	logic               res_f_q, done_q;

	logic [32:0]        trial;
	logic               div_ge;
	logic [63:0]        sq_sum;
	logic [31:0]        diff, dmag, bq, idx_sum;
	logic [15:0]        cur, mag_c, mag_n0, mag_n1, mag_n2;
	logic signed [32:0] dlt;
	logic               chg;
	logic [47:0]        ndvd;
	logic [63:0]        rnd;
	logic [30:0]        hq;
	logic               fin;

	assign pop = (state_q == S_IDLE) && !empty;

	assign trial  = {div_r_q, div_q_q[47]};
	assign div_ge = trial >= {1'b0, div_d_q};
	assign sq_sum = sq_r_q + sq_b_q;

	assign diff = cfg.ntop - cfg.nbot;
	assign dmag = diff[31] ? -diff : diff;
	assign bq   = div_q_q[31:0];

	// local index rounded to q1.14, never zero
	assign idx_sum = n30_q + 32'd32768;
	assign cur     = (idx_sum[31:16] == 16'd0) ? 16'd1 : idx_sum[31:16];
	assign dlt     = $signed({2'b0, e_q.prior, 16'd0}) - $signed({n30_q[31], n30_q});
	assign chg     = (dlt >= EPS30) || (dlt <= -EPS30);

	assign mag_c  = mag16(e_q.c[comp_q]);
	assign mag_n0 = mag16(n_q[0]);
	assign mag_n1 = mag16(n_q[1]);
	assign mag_n2 = mag16(n_q[2]);
	assign ndvd   = {2'b0, mag_c, 30'd0} + {17'd0, s_q[31:1]};
	assign rnd    = (mul_acc_q + 64'd536870912) >> 30;
	assign hq     = ONE30 - {mul_acc_q[28:0], 2'b0};

	// the sequencer hands a result over on this cycle
	assign fin = ((state_q == S_CHK) && (!chg_q || e_q.l2 == '0)) ||
		((state_q == S_PROD) && (mul_b_q == '0) && (mul_acc_q > PROD_LIM)) ||
		((state_q == S_ZM) && (mul_b_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mul_b_q <= '0;
			div_n_q <= '0;
			sq_b_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;

			// shared units step whenever they hold work
			if (mul_b_q != '0) begin
				if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
			end
			if (div_n_q != '0) begin
				div_r_q <= div_ge ? 32'(trial - {1'b0, div_d_q}) : trial[31:0];
				div_q_q <= {div_q_q[46:0], div_ge};
				div_n_q <= div_n_q - 6'd1;
			end
			if (sq_b_q != '0) begin
				if (sq_v_q >= sq_sum) begin
					sq_v_q <= sq_v_q - sq_sum;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end

			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						e_q <= head;
						if (head.cls == CLS_BAND) begin
							dneg_q    <= diff[31];
							mul_a_q   <= {32'd0, dmag};
							mul_b_q   <= {26'd0, head.w};
							mul_acc_q <= '0;
							state_q   <= S_BLMUL;
						end else begin
							n30_q   <= (head.cls == CLS_TOP) ? cfg.ntop : cfg.nbot;
							state_q <= S_IDX;
						end
					end
				end
				S_BLMUL: begin
					if (mul_b_q == '0) begin
						div_q_q <= mul_acc_q[47:0];
						div_r_q <= '0;
						div_d_q <= {13'd0, cfg.band, 1'b0};
						div_n_q <= DIV_STEPS;
						state_q <= S_BLDIV;
					end
				end
				S_BLDIV: begin
					if (div_n_q == '0) begin
						n30_q   <= cfg.nbot + $signed(dneg_q ? -bq : bq);
						state_q <= S_IDX;
					end
				end
				S_IDX: begin
					cur14_q <= cur;
					chg_q   <= chg;
					if (e_q.l2 == '0) begin
						n_q[0]  <= '0;
						n_q[1]  <= '0;
						n_q[2]  <= '0;
						state_q <= S_CHK;
					end else begin
						sq_v_q  <= {e_q.l2, 32'd0};
						sq_r_q  <= '0;
						sq_b_q  <= SQ_TOP;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_b_q == '0) begin
						s_q     <= sq_r_q[31:0];
						comp_q  <= 2'd0;
						state_q <= S_NSTART;
					end
				end
				S_NSTART: begin
					div_q_q <= ndvd;
					div_r_q <= '0;
					div_d_q <= s_q;
					div_n_q <= DIV_STEPS;
					state_q <= S_NDIV;
				end
				S_NDIV: begin
					if (div_n_q == '0) begin
						n_q[comp_q] <= clamp_mag({16'd0, div_q_q}, e_q.c[comp_q][15]);
						if (comp_q == 2'd2) begin
							state_q <= S_CHK;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= S_NSTART;
						end
					end
				end
				S_CHK: begin
					if (!chg_q || e_q.l2 == '0) begin
						res_x_q <= n_q[0];
						res_y_q <= n_q[1];
						res_z_q <= n_q[2];
						res_n_q <= chg_q ? cur14_q[14:0] : e_q.prior;
						res_f_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						div_q_q <= {3'd0, e_q.prior, 30'd0};
						div_r_q <= '0;
						div_d_q <= {16'd0, cur14_q};
						div_n_q <= DIV_STEPS;
						state_q <= S_KDIV;
					end
				end
				S_KDIV: begin
					if (div_n_q == '0) begin
						k30_q     <= div_q_q[44:0];
						mul_a_q   <= {19'd0, div_q_q[44:0]};
						mul_b_q   <= div_q_q[44:0];
						mul_acc_q <= '0;
						state_q   <= S_K2;
					end
				end
				S_K2: begin
					// products wrap at 64 bits
					if (mul_b_q == '0) begin
						k2_q      <= mul_acc_q[63:30];
						mul_a_q   <= {48'd0, mag_n1};
						mul_b_q   <= {29'd0, mag_n1};
						mul_acc_q <= '0;
						state_q   <= S_YSQ;
					end
				end
				S_YSQ: begin
					if (mul_b_q == '0) begin
						mul_a_q   <= {30'd0, k2_q};
						mul_b_q   <= {14'd0, hq};
						mul_acc_q <= '0;
						state_q   <= S_PROD;
					end
				end
				S_PROD: begin
					if (mul_b_q == '0) begin
						if (mul_acc_q > PROD_LIM) begin
							// total internal reflection
							res_x_q <= n_q[0];
							res_y_q <= -n_q[1];
							res_z_q <= n_q[2];
							res_n_q <= e_q.prior;
							res_f_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							sq_v_q  <= {33'd0, ONE30} - {30'd0, mul_acc_q[63:30]};
							sq_r_q  <= '0;
							sq_b_q  <= SQ_TOP;
							state_q <= S_YSQRT;
						end
					end
				end
				S_YSQRT: begin
					if (sq_b_q == '0) begin
						ry_q      <= clamp_mag((sq_r_q + 64'd1) >> 1, n_q[1][15]);
						mul_a_q   <= {19'd0, k30_q};
						mul_b_q   <= {29'd0, mag_n0};
						mul_acc_q <= '0;
						state_q   <= S_XM;
					end
				end
				S_XM: begin
					if (mul_b_q == '0) begin
						rx_q      <= clamp_mag(rnd, n_q[0][15]);
						mul_a_q   <= {19'd0, k30_q};
						mul_b_q   <= {29'd0, mag_n2};
						mul_acc_q <= '0;
						state_q   <= S_ZM;
					end
				end
				S_ZM: begin
					if (mul_b_q == '0) begin
						res_x_q <= rx_q;
						res_y_q <= ry_q;
						res_z_q <= clamp_mag(rnd, n_q[2][15]);
						res_n_q <= cur14_q[14:0];
						res_f_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_x      = res_x_q;
	assign out_y      = res_y_q;
	assign out_z      = res_z_q;
	assign next_index = res_n_q;
	assign reflected  = res_f_q;
	assign done       = done_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mul_b_q != '0, div_n_q != '0, sq_b_q != '0}) <= 1)
		else $error("two arithmetic units busy at once");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (mul_b_q == '0 && div_n_q == '0 && sq_b_q == '0))
		else $error("unit still running with sequencer idle");
`endif

endmodule

// File: rtl/graded_index_ray_refractor.sv
// top level of the graded-index ray refractor
// depends on gir_pkg, gir_cfg, gir_front and gir_back
//
// One ray step per item: start is taken while busy is low, and each item gives exactly one
// result, shown for a single cycle with done high; the receiver cannot hold results off.
// The front end takes an item and parks it in a two-entry queue, so up to
// three items can be in flight while the back end works. The back end runs one item at a
// time through a shared 48-step long divider, a 32-step square root and a shift-add
// multiplier. An item whose index does not change finishes without the refraction, an item
// inside the transition band first blends the two layer indices, and the sustained
// rate is set by that back-end sequencer. busy is also high after reset and after every
// register write while the layer indices are recomputed.
module graded_index_ray_refractor import gir_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] height,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [14:0]        prior_index,
	output logic               done,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic [14:0]        next_index,
	output logic               reflected
);

	cfg_t  cfg;
	item_t head;
	logic  recalc, empty, pop;

	gir_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.recalc  (recalc)
	);

	gir_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.recalc      (recalc),
		.band        (cfg.band),
		.height      (height),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.prior_index (prior_index),
		.pop         (pop),
		.busy        (busy),
		.empty       (empty),
		.head        (head)
	);

	gir_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.cfg        (cfg),
		.pop        (pop),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.next_index (next_index),
		.reflected  (reflected),
		.done       (done)
	);

endmodule

// File: dv/graded_index_ray_refractor_test.sv
// self-checking testbench for graded_index_ray_refractor: apb register phases, random ray items
// depends on gir_pkg and the rtl of the block; predicts every result and compares field by field
module graded_index_ray_refractor_test import gir_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [23:0] height;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [14:0]        prior;
	} ray_in_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [14:0]        idx;
		logic               refl;
	} ray_out_t;

	logic               clk, arst_n;
	logic               psel, penable, pwrite, pready;
	logic [3:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               start, busy, done;
	logic signed [23:0] height;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic [14:0]        prior_index;
	logic signed [15:0] out_x, out_y, out_z;
	logic [14:0]        next_index;
	logic               reflected;

	ray_in_t  pending_rays[$];
	ray_out_t expected_rays[$];
	int       idle_pct;
	int       mismatches;
	int unsigned top_temp, bot_temp, band_len;

	graded_index_ray_refractor u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	// index of a layer in q1.30 from its q7.8 temperature
	function automatic longint layer_index(input logic [63:0] t);
		logic [63:0] tb, ta;
		tb = (64'(IDX_BK) * t) >> 18;
		ta = (64'(IDX_AK) * t * t) >> 34;
		return longint'(64'(IDX_C30) - tb - ta);
	endfunction

	function automatic longint sat_mag(input logic [63:0] m, input logic neg);
		if (m > 64'd16384) m = 64'd16384;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic ray_out_t refract_ray(input ray_in_t ri);
		longint hh, lb, ntop, nbot, n30, d;
		longint c[3], n[3], r[3];
		logic [63:0] cur14, l2, s, m, k30, k2, hq, prod, v, ym, mx, mz;
		logic refl;
		logic [14:0] nxt;
		ray_out_t o;
		hh = ri.height;
		lb = band_len;
		ntop = layer_index(top_temp);
		nbot = layer_index(bot_temp);
		c[0] = ri.dx;
		c[1] = ri.dy;
		c[2] = ri.dz;
		refl = 1'b0;
		nxt = ri.prior;
		if (2 * hh > lb) n30 = ntop;
		else if (2 * hh < -lb) n30 = nbot;
		else if (lb == 0) n30 = nbot;
		else n30 = nbot + ((ntop - nbot) * (2 * hh + lb)) / (2 * lb);
		cur14 = (64'(n30) + 64'd32768) >> 16;
		if (cur14 == 0) cur14 = 1;
		l2 = 64'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
		if (l2 == 0) begin
			for (int i = 0; i < 3; i++) n[i] = 0;
		end else begin
			s = root64(l2 << 32);
			for (int i = 0; i < 3; i++) begin
				m = 64'(c[i] < 0 ? -c[i] : c[i]);
				n[i] = sat_mag(((m << 30) + s / 2) / s, c[i] < 0);
			end
		end
		for (int i = 0; i < 3; i++) r[i] = n[i];
		d = (longint'(ri.prior) << 16) - n30;
		if (d < 0) d = -d;
		if (d >= 1073742) begin
			nxt = cur14[14:0];
			if (l2 != 0) begin
				k30 = (64'(ri.prior) << 30) / cur14;
				k2 = (k30 * k30) >> 30;
				hq = (64'd1 << 30) - 64'((n[1] * n[1]) << 2);
				prod = k2 * hq;
				if (prod > (64'd1 << 60)) begin
					// total internal reflection: mirror y, stay in the old medium
					r[1] = -n[1];
					refl = 1'b1;
					nxt = ri.prior;
				end else begin
					v = (64'd1 << 30) - (prod >> 30);
					ym = (root64(v) + 1) >> 1;
					mx = 64'(n[0] < 0 ? -n[0] : n[0]);
					mz = 64'(n[2] < 0 ? -n[2] : n[2]);
					r[0] = sat_mag((k30 * mx + (64'd1 << 29)) >> 30, n[0] < 0);
					r[2] = sat_mag((k30 * mz + (64'd1 << 29)) >> 30, n[2] < 0);
					r[1] = sat_mag(ym, n[1] < 0);
				end
			end
		end
		o.x = r[0][15:0];
		o.y = r[1][15:0];
		o.z = r[2][15:0];
		o.idx = nxt;
		o.refl = refl;
		return o;
	endfunction

	// driver: an item is taken at an edge with start high and busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			height <= '0;
			dir_x <= '0;
			dir_y <= '0;
			dir_z <= '0;
			prior_index <= '0;
		end else begin
			logic free;
			ray_in_t ri;
			free = !start;
			if (start && !busy) begin
				expected_rays.push_back(refract_ray({height, dir_x, dir_y, dir_z, prior_index}));
				free = 1'b1;
			end
			if (free) begin
				if (pending_rays.size() > 0 && $urandom_range(99) >= idle_pct) begin
					ri = pending_rays.pop_front();
					height <= ri.height;
					dir_x <= ri.dx;
					dir_y <= ri.dy;
					dir_z <= ri.dz;
					prior_index <= ri.prior;
					start <= 1'b1;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor: each done cycle carries one result
	always @(posedge clk) begin
		if (arst_n && done) begin
			ray_out_t e;
			if (expected_rays.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h %h %h %b",
					out_x, out_y, out_z, next_index, reflected);
			end else begin
				e = expected_rays.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
				    next_index !== e.idx || reflected !== e.refl) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp x %h y %h z %h idx %h refl %b, got %h %h %h %h %b",
							e.x, e.y, e.z, e.idx, e.refl,
							out_x, out_y, out_z, next_index, reflected);
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TOP:  if (val <= TEMP_MAX) top_temp = val;
			REG_BOT:  if (val <= TEMP_MAX) bot_temp = val;
			REG_BAND: if (val <= BAND_MAX) band_len = val;
			default: ;
		endcase
	endtask

	task automatic add_ray(input int h, input int x, input int y, input int z, input int p);
		ray_in_t ri;
		ri.height = h[23:0];
		ri.dx = x[15:0];
		ri.dy = y[15:0];
		ri.dz = z[15:0];
		ri.prior = p[14:0];
		pending_rays.push_back(ri);
	endtask

	task automatic add_random_ray();
		int h, x, y, z, p, half;
		half = band_len / 2;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: h = int'($urandom_range(band_len + 8)) - half - 4;
			5: h = ($urandom_range(1) ? half : -half) + int'($urandom_range(2)) - 1;
			6: h = 0;
			default: h = $urandom;
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: p = 21500 + $urandom_range(400);
			6, 7: p = $urandom;
			default: p = $urandom_range(1) ? 32767 : 0;
		endcase
		x = $urandom;
		y = $urandom;
		z = $urandom;
		case ($urandom_range(9))
			7: begin
				x = int'($urandom_range(64)) - 32;
				y = int'($urandom_range(64)) - 32;
				z = int'($urandom_range(64)) - 32;
			end
			8: begin
				x = 0;
				z = 0;
			end
			9: begin
				x = $urandom_range(1) ? 0 : -32768;
				y = x;
				z = x;
			end
			default: ;
		endcase
		add_ray(h, x, y, z, p);
	endtask

	task automatic wait_drained();
		while (pending_rays.size() > 0 || start || expected_rays.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int temps[6][3];
		int idles[6];
		temps = '{'{24320, 0, 65536}, '{0, 0, 0}, '{0, 24320, 131072},
		          '{24320, 24320, 0}, '{12000, 3000, 1}, '{-1, -1, -1}};
		idles = '{0, 65, 0, 29, 65, 0};
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		mismatches = 0;
		top_temp = 0;
		bot_temp = 0;
		band_len = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			repeat (8) @(posedge clk);
			if (temps[ph][0] < 0) begin
				write_reg(REG_TOP, $urandom_range(24320));
				write_reg(REG_BOT, $urandom_range(24320));
				write_reg(REG_BAND, $urandom_range(131072));
				// out-of-range writes must leave the registers alone
				write_reg(REG_TOP, 32'd30000);
				write_reg(REG_BAND, 32'hFFFF_FFFF);
			end else begin
				write_reg(REG_TOP, temps[ph][0]);
				write_reg(REG_BOT, temps[ph][1]);
				write_reg(REG_BAND, temps[ph][2]);
			end
			idle_pct = idles[ph];
			if (ph == 0) begin
				add_ray(0, 16384, 4000, 0, 21700);
				add_ray(32768, 1000, 1000, 1000, 21000);
				add_ray(-32768, 1000, 1000, 1000, 21000);
				add_ray(32769, 1000, -1000, 1000, 21000);
				add_ray(-32769, -1000, 1000, -1000, 22000);
				add_ray(8388607, 32767, 32767, 32767, 21591);
				add_ray(-8388608, -32768, -32768, -32768, 21839);
				add_ray(100, 0, 0, 0, 20000);
				add_ray(100, 0, 0, 0, 21715);
				add_ray(-5000, 0, 9000, 0, 21000);
				add_ray(-5000, 0, -9000, 0, 23000);
				add_ray(20000, 3000, 2000, -1000, 0);
				add_ray(-20000, 3000, -500, 3000, 32767);
				add_ray(-20000, 3000, 16000, 3000, 32767);
				add_ray(40000, 1, -1, 1, 21591);
				add_ray(-40000, 12345, -6789, 2345, 21839);
				add_ray(0, -32768, 32767, 0, 21839);
				add_ray(1, 1, 0, 0, 1);
			end
			for (int i = 0; i < 290; i++) add_random_ray();
		end
		wait_drained();
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
